/* hw/rtl/thcpe_pkg.sv */
// thcpe_pkg: shared types, status codes and color scaling functions for the
// texture header checker and pixel expander. No dependencies.
`default_nettype none

package thcpe_pkg;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OUT_W    = 64;

  // result kinds carried on tuser
  localparam logic [STATUS_W-1:0] ST_PIXEL     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_MODE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_MIPS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_DIM  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd4;

  localparam logic [WORD_W-1:0] MODE_RGB565   = 16'h0000;
  localparam logic [WORD_W-1:0] MODE_ARGB4444 = 16'h0500;

  // v*255/31 and v*255/63 folded with a 2^-20 reciprocal into one constant
  localparam logic [23:0] SCALE5 = 24'd8625630;
  localparam logic [23:0] SCALE6 = 24'd4244475;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // floor(v*255/31) for a 5-bit field
  function automatic logic [CHAN_W-1:0] scale5(input logic [4:0] v);
    logic [28:0] prod;
    prod = {24'd0, v} * {5'd0, SCALE5};
    return prod[27:20];
  endfunction

  // floor(v*255/63) for a 6-bit field
  function automatic logic [CHAN_W-1:0] scale6(input logic [5:0] v);
    logic [29:0] prod;
    prod = {24'd0, v} * {6'd0, SCALE6};
    return prod[27:20];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/thcpe_expand.sv */
// thcpe_expand: turns one 16-bit pixel word into 8-bit ARGB, either from
// ARGB4444 or from RGB565 with opaque alpha. Depends on thcpe_pkg.
`default_nettype none

module thcpe_expand import thcpe_pkg::*; (
  input  wire logic [WORD_W-1:0] word,
  input  wire logic              alpha_mode,
  output pixel_t                 pix
);

  always_comb begin
    if (alpha_mode) begin
      // n*255/15 is the nibble repeated
      pix.alpha = {word[15:12], word[15:12]};
      pix.red   = {word[11:8],  word[11:8]};
      pix.green = {word[7:4],   word[7:4]};
      pix.blue  = {word[3:0],   word[3:0]};
    end else begin
      pix.alpha = 8'hFF;
      pix.red   = scale5(word[15:11]);
      pix.green = scale6(word[10:5]);
      pix.blue  = scale5(word[4:0]);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tex_header_check_and_pixel_expand.sv */
// tex_header_check_and_pixel_expand: parses a texture file header, checks it
// and expands the pixel words to 8-bit ARGB. Each accepted word is held in an
// input register and its result goes to a result register; one item is
// accepted every cycle while the result side keeps up. Synchronous active-low
// reset empties both registers and returns the parser to idle.
// Depends on thcpe_pkg and thcpe_expand.
`default_nettype none

module tex_header_check_and_pixel_expand import thcpe_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [WORD_W-1:0]   in_tdata,   // [15:0] data_word
  input  wire logic                in_tuser,   // [0] first_word
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OUT_W-1:0]         out_tdata,  // alpha, red, green, blue, width, height
  output logic                     out_tlast,  // last_pixel
  output logic [STATUS_W-1:0]      out_tuser   // [2:0] status
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_MIPS   = 4'd1;
  localparam logic [3:0] PH_WIDTH  = 4'd2;
  localparam logic [3:0] PH_HEIGHT = 4'd3;
  localparam logic [3:0] PH_SKIP1  = 4'd4;
  localparam logic [3:0] PH_W2     = 4'd5;
  localparam logic [3:0] PH_H2     = 4'd6;
  localparam logic [3:0] PH_SKIP2  = 4'd7;
  localparam logic [3:0] PH_PIXELS = 4'd8;

  localparam logic [3:0] SKIP_FIRST  = 4'd14;
  localparam logic [3:0] SKIP_SECOND = 4'd6;

  // input register
  logic              s1_valid_r;
  logic [WORD_W-1:0] s1_data_r;
  logic              s1_first_r;

  // parser state
  logic [3:0]        phase_r, phase_nxt;
  logic [3:0]        skip_r, skip_nxt;
  logic              alpha_mode_r, alpha_mode_nxt;
  logic [WORD_W-1:0] width_r, width_nxt;
  logic [WORD_W-1:0] height_r, height_nxt;
  logic [31:0]       pixels_left_r, pixels_left_nxt;
  logic              dims_differ_r, dims_differ_nxt;

  // result register
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;
  logic                out_last_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                s1_go;
  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic                res_last;
  logic                res_pixel;
  pixel_t              pix;
  pixel_t              res_pix;

  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  thcpe_expand u_expand (
    .word       (s1_data_r),
    .alpha_mode (alpha_mode_r),
    .pix        (pix)
  );

  always_comb begin
    phase_nxt       = phase_r;
    skip_nxt        = skip_r;
    alpha_mode_nxt  = alpha_mode_r;
    width_nxt       = width_r;
    height_nxt      = height_r;
    pixels_left_nxt = pixels_left_r;
    dims_differ_nxt = dims_differ_r;
    res_valid       = 1'b0;
    res_status      = ST_PIXEL;
    res_last        = 1'b0;
    res_pixel       = 1'b0;
    if (s1_first_r) begin
      width_nxt       = '0;
      height_nxt      = '0;
      dims_differ_nxt = 1'b0;
      pixels_left_nxt = '0;
      skip_nxt        = '0;
      if (s1_data_r != MODE_RGB565 && s1_data_r != MODE_ARGB4444) begin
        res_valid  = 1'b1;
        res_status = ST_BAD_MODE;
        phase_nxt  = PH_IDLE;
      end else begin
        alpha_mode_nxt = (s1_data_r == MODE_ARGB4444);
        phase_nxt      = PH_MIPS;
      end
    end else begin
      case (phase_r)
        PH_MIPS: begin
          if (s1_data_r == '0) begin
            res_valid  = 1'b1;
            res_status = ST_ZERO_MIPS;
            phase_nxt  = PH_IDLE;
          end else begin
            phase_nxt = PH_WIDTH;
          end
        end
        PH_WIDTH: begin
          width_nxt = s1_data_r;
          phase_nxt = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          height_nxt = s1_data_r;
          if (width_r == '0 || s1_data_r == '0) begin
            res_valid  = 1'b1;
            res_status = ST_ZERO_DIM;
            phase_nxt  = PH_IDLE;
          end else begin
            skip_nxt  = SKIP_FIRST;
            phase_nxt = PH_SKIP1;
          end
        end
        PH_SKIP1: begin
          skip_nxt = skip_r - 4'd1;
          if (skip_r == 4'd1) begin
            phase_nxt = PH_W2;
          end
        end
        PH_W2: begin
          dims_differ_nxt = (s1_data_r != width_r);
          phase_nxt       = PH_H2;
        end
        PH_H2: begin
          if (dims_differ_r || s1_data_r != height_r) begin
            res_valid  = 1'b1;
            res_status = ST_MISMATCH;
            phase_nxt  = PH_IDLE;
          end else begin
            skip_nxt  = SKIP_SECOND;
            phase_nxt = PH_SKIP2;
          end
        end
        PH_SKIP2: begin
          skip_nxt = skip_r - 4'd1;
          if (skip_r == 4'd1) begin
            pixels_left_nxt = {16'd0, width_r} * {16'd0, height_r};
            phase_nxt       = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          res_valid       = 1'b1;
          res_pixel       = 1'b1;
          pixels_left_nxt = pixels_left_r - 32'd1;
          res_last        = (pixels_left_r == 32'd1);
          if (pixels_left_r == 32'd1) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    // error results carry zero color
    res_pix = res_pixel ? pix : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_r       <= PH_IDLE;
      skip_r        <= '0;
      alpha_mode_r  <= 1'b0;
      width_r       <= '0;
      height_r      <= '0;
      pixels_left_r <= '0;
      dims_differ_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_go) begin
        phase_r       <= phase_nxt;
        skip_r        <= skip_nxt;
        alpha_mode_r  <= alpha_mode_nxt;
        width_r       <= width_nxt;
        height_r      <= height_nxt;
        pixels_left_r <= pixels_left_nxt;
        dims_differ_r <= dims_differ_nxt;
        out_valid_r   <= res_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r  <= in_tdata;
      s1_first_r <= in_tuser;
    end
    if (s1_go && res_valid) begin
      out_data_r   <= {height_nxt, width_nxt, res_pix.blue, res_pix.green,
                       res_pix.red, res_pix.alpha};
      out_last_r   <= res_last;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire
